### sv/sem_pkg.sv
// sem_pkg: shared widths, constants, register indexes and the gradient tap type
// for the sobel edge magnitude stream core; depends on nothing
package sem_pkg;

	// pixel and geometry widths
	localparam int PIX_W       = 8;
	localparam int ROW_W       = 16;
	localparam int WIDTH_RAW_W = 11;

	// line store geometry default
	localparam int MAX_WIDTH_DEF = 1024;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	// register reset values and smallest meaningful image side
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_DIM      = 3;

	// gradient arithmetic
	localparam int GRAD_W      = 11;
	localparam int SUM_W       = GRAD_W + 1;
	localparam int PROD_W      = SUM_W + 3;
	localparam int SOBEL_NUM   = 7;
	localparam int RECIP_10    = 6554;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int MUL_W       = PROD_W + RECIP_W;
	localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// one window result handed from the window stage to the magnitude pipeline
	typedef struct packed {
		logic                     border;
		logic                     last;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} sem_tap_t;

endpackage

### sv/sem_pix_if.sv
// sem_pix_if: pixel input channel with valid/ready handshake
// depends on sem_pkg for the pixel width
interface sem_pix_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [sem_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output mode, output pixel, input ready);
	modport sink   (input valid, input mode, input pixel, output ready);
endinterface

### sv/sem_res_if.sv
// sem_res_if: result output channel with valid/ready handshake
// depends on sem_pkg for the pixel width
interface sem_res_if;
	logic                      valid;
	logic                      ready;
	logic [sem_pkg::PIX_W-1:0] edge_value;
	logic                      frame_end;

	modport source (output valid, output edge_value, output frame_end, input ready);
	modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface

### sv/sem_cfg_if.sv
// sem_cfg_if: configuration write channel carrying register index and data
// depends on sem_pkg for index and data widths
interface sem_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sem_pkg::CFG_IDX_W-1:0]  index;
	logic [sem_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/sem_ram.sv
// sem_ram: generic simple dual-port ram, one write and one registered read per cycle
// read during write to the same address returns the old contents; no dependencies
module sem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/sem_front.sv
// sem_front: position counters, line store ram with write-back forwarding,
// 3x3 window and sobel gradients; depends on sem_pkg, sem_pix_if and sem_ram
module sem_front #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sem_pix_if.sink                      pixels,
	input  logic [$clog2(MAX_WIDTH)-1:0] w_last,
	input  logic [sem_pkg::ROW_W-1:0]    h_last,
	input  logic                         restart,
	output logic                         tap_valid,
	input  logic                         tap_ready,
	output sem_pkg::sem_tap_t            tap
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int PIX_W  = sem_pkg::PIX_W;
	localparam int LINE_W = 2 * PIX_W;
	localparam int GRAD_W = sem_pkg::GRAD_W;

	// input row progress, saturates at ROW_LATER
	localparam logic [1:0] ROW_FIRST  = 2'd0;
	localparam logic [1:0] ROW_SECOND = 2'd1;
	localparam logic [1:0] ROW_LATER  = 2'd2;

	logic [COL_W-1:0]          in_col_q;
	logic [1:0]                in_row_q;
	logic [COL_W-1:0]          out_col_q;
	logic [sem_pkg::ROW_W-1:0] out_row_q;

	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             border_s1;
	logic             last_s1;

	logic              fwd_q;
	logic [LINE_W-1:0] fwd_data_q;

	logic [PIX_W-1:0] win_q  [3][3];
	logic [PIX_W-1:0] win_nx [3][3];

	logic              accept;
	logic              adv;
	logic [PIX_W-1:0]  px_in;
	logic              emit_in;
	logic              col_end;
	logic              ocol_end;
	logic              orow_end;
	logic              border_in;
	logic              last_in;
	logic [LINE_W-1:0] ram_rd;
	logic [LINE_W-1:0] line_rd;
	logic [PIX_W-1:0]  up_rd;
	logic [PIX_W-1:0]  mid_rd;

	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	function automatic logic signed [GRAD_W-1:0] sx(input logic [PIX_W-1:0] p);
		return $signed({{(GRAD_W - PIX_W){1'b0}}, p});
	endfunction

	// handshake: stage 1 frees when its item moves on or needs no result slot
	assign accept       = pixels.valid && pixels.ready;
	assign adv          = valid_s1 && (!emit_s1 || tap_ready);
	assign pixels.ready = !valid_s1 || adv;

	// position decode for the incoming request
	assign px_in     = pixels.mode ? '0 : pixels.pixel;
	assign emit_in   = (in_row_q == ROW_LATER) || ((in_row_q == ROW_SECOND) && (in_col_q != '0));
	assign col_end   = (in_col_q == w_last);
	assign ocol_end  = (out_col_q == w_last);
	assign orow_end  = (out_row_q == h_last);
	assign border_in = (out_row_q == '0) || orow_end || (out_col_q == '0) || ocol_end;
	assign last_in   = emit_in && orow_end && ocol_end;

	// upper line in the high byte, middle line in the low byte
	sem_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (ram_rd),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data ({mid_rd, px_s1})
	);

	// forward the write-back when the next request hits the same column
	assign line_rd = fwd_q ? fwd_data_q : ram_rd;
	assign up_rd   = line_rd[LINE_W-1:PIX_W];
	assign mid_rd  = line_rd[PIX_W-1:0];

	// window shift with the new column on the right
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
		end
		win_nx[0][2] = up_rd;
		win_nx[1][2] = mid_rd;
		win_nx[2][2] = px_s1;
	end

	// sobel x and y kernels on the shifted window
	always_comb begin
		gx = (sx(win_nx[0][2]) - sx(win_nx[0][0]))
		   + ((sx(win_nx[1][2]) - sx(win_nx[1][0])) <<< 1)
		   + (sx(win_nx[2][2]) - sx(win_nx[2][0]));
		gy = (sx(win_nx[2][0]) - sx(win_nx[0][0]))
		   + ((sx(win_nx[2][1]) - sx(win_nx[0][1])) <<< 1)
		   + (sx(win_nx[2][2]) - sx(win_nx[0][2]));
	end

	assign tap_valid  = valid_s1 && emit_s1;
	assign tap.border = border_s1;
	assign tap.last   = last_s1;
	assign tap.gx     = gx;
	assign tap.gy     = gy;

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= ROW_FIRST;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= ROW_FIRST;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				in_col_q  <= '0;
				in_row_q  <= ROW_FIRST;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= col_end ? '0 : in_col_q + COL_W'(1);
				if (col_end && (in_row_q != ROW_LATER)) begin
					in_row_q <= in_row_q + 2'd1;
				end
				if (emit_in) begin
					out_col_q <= ocol_end ? '0 : out_col_q + COL_W'(1);
					if (ocol_end) begin
						out_row_q <= out_row_q + sem_pkg::ROW_W'(1);
					end
				end
			end
		end
	end

	// stage 1 control, forwarding flag and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_q    <= adv && (in_col_q == col_s1);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				win_q <= win_nx;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= px_in;
			col_s1     <= in_col_q;
			emit_s1    <= emit_in;
			border_s1  <= border_in;
			last_s1    <= last_in;
			fwd_data_q <= {mid_rd, px_s1};
		end
	end

endmodule

### sv/sem_mag.sv
// sem_mag: gradient magnitude pipeline, scale by 7/10, clamp, invert, output register
// depends on sem_pkg and sem_res_if
module sem_mag (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tap_valid,
	output logic              tap_ready,
	input  sem_pkg::sem_tap_t tap,
	sem_res_if.source         results
);

	localparam int GRAD_W = sem_pkg::GRAD_W;
	localparam int SUM_W  = sem_pkg::SUM_W;
	localparam int PROD_W = sem_pkg::PROD_W;
	localparam int MUL_W  = sem_pkg::MUL_W;
	localparam int QUOT_W = sem_pkg::QUOT_W;
	localparam int PIX_W  = sem_pkg::PIX_W;

	logic              valid_s2;
	sem_pkg::sem_tap_t tap_s2;

	logic              valid_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              border_s3;
	logic              last_s3;

	logic             res_valid_q;
	logic [PIX_W-1:0] edge_q;
	logic             frame_end_q;

	logic              out_free;
	logic              s3_free;
	logic              s2_free;
	logic [GRAD_W-1:0] ax;
	logic [GRAD_W-1:0] ay;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [MUL_W-1:0]  scaled;
	logic [QUOT_W-1:0] quot;
	logic [PIX_W-1:0]  mag;
	logic [PIX_W-1:0]  edge_nx;

	// ready chain, each stage frees when empty or moving on
	assign out_free  = !res_valid_q || results.ready;
	assign s3_free   = !valid_s3 || out_free;
	assign s2_free   = !valid_s2 || s3_free;
	assign tap_ready = s2_free;

	// |gx| + |gy| scaled by seven
	assign ax   = tap_s2.gx[GRAD_W-1] ? GRAD_W'(-tap_s2.gx) : GRAD_W'(tap_s2.gx);
	assign ay   = tap_s2.gy[GRAD_W-1] ? GRAD_W'(-tap_s2.gy) : GRAD_W'(tap_s2.gy);
	assign sum  = SUM_W'(ax) + SUM_W'(ay);
	assign prod = PROD_W'(sum) * PROD_W'(sem_pkg::SOBEL_NUM);

	// divide by ten through the reciprocal, exact over the product range
	assign scaled  = MUL_W'(prod_s3) * MUL_W'(sem_pkg::RECIP_10);
	assign quot    = scaled[MUL_W-1:sem_pkg::RECIP_SHIFT];
	assign mag     = (quot > QUOT_W'(sem_pkg::PIX_MAX)) ? sem_pkg::PIX_MAX : quot[PIX_W-1:0];
	assign edge_nx = border_s3 ? sem_pkg::PIX_MAX : (sem_pkg::PIX_MAX - mag);

	assign results.valid      = res_valid_q;
	assign results.edge_value = edge_q;
	assign results.frame_end  = frame_end_q;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= tap_valid;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				res_valid_q <= valid_s3;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (s2_free && tap_valid) begin
			tap_s2 <= tap;
		end
		if (s3_free && valid_s2) begin
			prod_s3   <= prod;
			border_s3 <= tap_s2.border;
			last_s3   <= tap_s2.last;
		end
		if (out_free && valid_s3) begin
			edge_q      <= edge_nx;
			frame_end_q <= last_s3;
		end
	end

endmodule

### sv/sobel_edge_magnitude_stream_core.sv
// Sobel edge magnitude stream core. Gray pixels enter in raster order on the pixels channel,
// one request per clock when the result side keeps up; the line stores sit in one ram of
// MAX_WIDTH entries holding the upper and middle lines side by side, read and written back
// once per request, so the sustained rate is one pixel per cycle. Each result is
// 255 - min(255, (|gx|+|gy|)*7/10), and 255 on the border rows and columns. A result
// belongs to the pixel width+1 requests back, so each frame is followed by width+1 padding
// requests (mode 1) to flush it; frame_end marks the last result. Beyond that lag a result
// passes stage 1 in sem_front, then the s2, s3 and output registers of sem_mag. Writing
// image_width or image_height restarts the frame and is to be done only while the core is idle,
// which the core does not enforce; the width is clamped to 3..MAX_WIDTH, the height raised to at least 3.
// depends on sem_pkg, the three channel interfaces, sem_front and sem_mag
module sobel_edge_magnitude_stream_core #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sem_pix_if.sink   pixels,
	sem_res_if.source results,
	sem_cfg_if.sink   cfg
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = sem_pkg::ROW_W;

	logic [COL_W-1:0]  w_last_q;
	logic [ROW_W-1:0]  h_last_q;
	logic              cfg_wr;
	logic              restart;
	logic              tap_valid;
	logic              tap_ready;
	sem_pkg::sem_tap_t tap;

	// last column index of the effective width
	function automatic logic [COL_W-1:0] width_last(
		input logic [sem_pkg::WIDTH_RAW_W-1:0] raw
	);
		int w;
		w = int'(raw);
		if (w < sem_pkg::MIN_DIM) w = sem_pkg::MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return COL_W'(w - 1);
	endfunction

	// last row index of the effective height
	function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] raw);
		return (raw < ROW_W'(sem_pkg::MIN_DIM)) ? ROW_W'(sem_pkg::MIN_DIM - 1)
		                                        : raw - ROW_W'(1);
	endfunction

	// register decode, any known register write restarts the frame
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign restart   = cfg_wr && ((cfg.index == sem_pkg::REG_WIDTH) ||
	                              (cfg.index == sem_pkg::REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= width_last(sem_pkg::WIDTH_RAW_W'(sem_pkg::WIDTH_RESET));
			h_last_q <= height_last(ROW_W'(sem_pkg::HEIGHT_RESET));
		end else if (cfg_wr) begin
			case (cfg.index)
				sem_pkg::REG_WIDTH: begin
					w_last_q <= width_last(cfg.data[sem_pkg::WIDTH_RAW_W-1:0]);
				end
				sem_pkg::REG_HEIGHT: begin
					h_last_q <= height_last(cfg.data[ROW_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	sem_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.w_last    (w_last_q),
		.h_last    (h_last_q),
		.restart   (restart),
		.tap_valid (tap_valid),
		.tap_ready (tap_ready),
		.tap       (tap)
	);

	sem_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap_valid (tap_valid),
		.tap_ready (tap_ready),
		.tap       (tap),
		.results   (results)
	);

endmodule
